### sv/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared types, status codes and hash constants for the seeded pattern
// stream checker.
// ----------------------------------------------------------------------------
package spsc_pkg;

	// field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SIZE_W   = 15;
	localparam int unsigned COUNT_W  = 52;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SEED_W   = 32;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 52;
	localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'd1;
	localparam logic [SEED_W-1:0]  SEED_RST  = 32'd1;
	localparam logic [COUNT_W-1:0] TOTAL_RST = 52'd67108864;

	// sizing defaults
	localparam int unsigned CHUNK_MAX_DEF   = 16384;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CHUNK    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXTRA    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;
	localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;

	// pattern hash
	localparam logic [63:0] GOLDEN     = 64'h9E3779B97F4A7C15;
	localparam int unsigned OFF_SHIFT  = 3;
	localparam int unsigned SEED_SHIFT = 40;
	localparam int unsigned MIX_SHIFT  = 31;

	// excess saturation
	localparam logic [SIZE_W-1:0] EXCESS_MAX = 15'h7FFF;

	// input beat
	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              chunk_first;
		logic [SIZE_W-1:0] chunk_size;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  byte_offset;
		logic [SIZE_W-1:0]   excess_bytes;
		logic [COUNT_W-1:0]  verified_bytes;
		logic                stream_passed;
	} out_beat_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                check;
		logic [BYTE_W-1:0]   rx_byte;
		logic [COUNT_W-1:0]  byte_offset;
		logic [SIZE_W-1:0]   excess_bytes;
		logic [COUNT_W-1:0]  count_before;
		logic [COUNT_W-1:0]  verified_bytes;
		logic                stream_passed;
	} chk_item_t;

endpackage

### sv/seeded_pattern_stream_checker.sv
// ----------------------------------------------------------------------------
// seeded_pattern_stream_checker
// Checks a received byte stream, chunk by chunk, against a seeded pattern.
// ----------------------------------------------------------------------------
// Usage
//   in channel  : one received byte per beat (in_valid / in_stall), with a
//                 chunk-first mark and the chunk size on the first byte.
//   out channel : one result beat per input beat (out_valid / out_stall):
//                 status, stream offset, excess count, verified count and
//                 the pass flag.
//   cfg port    : cfg_wen / cfg_index / cfg_data write the seed (index 0)
//                 and the expected total (index 1); write only while idle.
// Timing
//   throughput is one byte per cycle while in_stall is low, set by the chunk
//   bookkeeping loop in the front, which updates the counts for each accepted byte.
//   from input accept, a byte passes the queue, the hash input, the partial
//   products and the compare into the output register.
// Reset
//   seed 1, total 67108864, verified count 0, no chunk open, not failed.
// Stalls
//   while out_stall holds a result, the back pipeline freezes; bytes keep
//   being accepted into a 4-entry queue, and in_stall rises once it is full.
// ----------------------------------------------------------------------------
module seeded_pattern_stream_checker #(
	parameter int unsigned CHUNK_MAX   = spsc_pkg::CHUNK_MAX_DEF,
	parameter int unsigned QUEUE_DEPTH = spsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [spsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  spsc_pkg::in_beat_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output spsc_pkg::out_beat_t             out_data
);
	import spsc_pkg::*;

	logic [SEED_W-1:0]  seed_q;
	logic [COUNT_W-1:0] total_q;

	logic      in_fire;
	logic      q_full;
	logic      q_valid;
	logic      q_pop;
	chk_item_t front_item;
	chk_item_t q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= SEED_RST;
			total_q <= TOTAL_RST;
		end else if (cfg_wen) begin
			if (cfg_index == REG_SEED) begin
				seed_q <= cfg_data[SEED_W-1:0];
			end
			if (cfg_index == REG_TOTAL) begin
				total_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	// input beat accepted straight into the queue
	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	spsc_front #(
		.CHUNK_MAX (CHUNK_MAX)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (in_fire),
		.in_data (in_data),
		.total   (total_q),
		.item    (front_item)
	);

	spsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_fire),
		.wdata  (front_item),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_data)
	);

	spsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

### sv/spsc_front.sv
// ----------------------------------------------------------------------------
// spsc_front
// Chunk bookkeeping: tracks the verified count, the open chunk and the
// extra-bytes failure, and classifies each byte assuming it matches.
// ----------------------------------------------------------------------------
module spsc_front #(
	parameter int unsigned CHUNK_MAX = spsc_pkg::CHUNK_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  spsc_pkg::in_beat_t            in_data,
	input  logic [spsc_pkg::COUNT_W-1:0]  total,
	output spsc_pkg::chk_item_t           item
);
	import spsc_pkg::*;

	localparam int unsigned LEN_W = $clog2(CHUNK_MAX + 1);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] next_off_q;
	logic [LEN_W-1:0]   rem_q;
	logic               failed_q;

	logic [31:0]        size_w;
	logic [31:0]        clamp_w;
	logic [LEN_W-1:0]   len_cl;
	logic [COUNT_W+1:0] diff;
	logic               extra;
	logic [SIZE_W-1:0]  excess_sat;
	logic [COUNT_W-1:0] cur_off;
	logic [COUNT_W-1:0] off_inc;
	logic [LEN_W-1:0]   rem_cur;
	logic               last;
	logic               count_eq;
	logic               next_eq;
	logic               stray;

	// clamp the chunk size into 1..CHUNK_MAX
	always_comb begin
		size_w = 32'(in_data.chunk_size);
		if (size_w == 32'd0) begin
			clamp_w = 32'd1;
		end else if (size_w > 32'(CHUNK_MAX)) begin
			clamp_w = 32'(CHUNK_MAX);
		end else begin
			clamp_w = size_w;
		end
		len_cl = LEN_W'(clamp_w);
	end

	// end-of-stream check for a new chunk
	always_comb begin
		diff = {2'b00, count_q} + (COUNT_W+2)'(len_cl) - {2'b00, total};
		extra = !diff[COUNT_W+1] && (diff != '0);
		excess_sat = (diff[COUNT_W:SIZE_W] != '0) ? EXCESS_MAX : diff[SIZE_W-1:0];
	end

	// offset and remaining length of this byte
	always_comb begin
		cur_off  = in_data.chunk_first ? count_q : next_off_q;
		rem_cur  = in_data.chunk_first ? len_cl : rem_q;
		off_inc  = cur_off + COUNT_W'(1);
		last     = (rem_cur == LEN_W'(1));
		count_eq = (count_q == total);
		next_eq  = (off_inc == total);
		stray    = !in_data.chunk_first && (rem_q == '0);
	end

	// classification, speculating on a match
	always_comb begin
		item.rx_byte        = in_data.rx_byte;
		item.status         = ST_IGNORED;
		item.check          = 1'b0;
		item.byte_offset    = count_q;
		item.excess_bytes   = '0;
		item.count_before   = count_q;
		item.verified_bytes = count_q;
		item.stream_passed  = 1'b0;
		if (failed_q) begin
			item.status = ST_IGNORED;
		end else if (stray) begin
			item.stream_passed = count_eq;
		end else if (in_data.chunk_first && extra) begin
			item.status       = ST_EXTRA;
			item.excess_bytes = excess_sat;
		end else begin
			item.check       = 1'b1;
			item.byte_offset = cur_off;
			if (last) begin
				item.status         = next_eq ? ST_COMPLETE : ST_CHUNK;
				item.verified_bytes = off_inc;
				item.stream_passed  = next_eq;
			end else begin
				item.status        = ST_MATCH;
				item.stream_passed = count_eq;
			end
		end
	end

	// chunk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			next_off_q <= '0;
			rem_q      <= '0;
			failed_q   <= 1'b0;
		end else if (fire && !failed_q && !stray) begin
			if (in_data.chunk_first && extra) begin
				failed_q <= 1'b1;
				rem_q    <= '0;
			end else begin
				next_off_q <= off_inc;
				if (last) begin
					count_q <= off_inc;
					rem_q   <= '0;
				end else begin
					rem_q <= rem_cur - LEN_W'(1);
				end
			end
		end
	end

	// a failure is never cleared except by reset
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("front failure flag cleared");

	// no chunk stays open after a failure
	a_closed_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> (rem_q == '0))
		else $error("chunk open after failure");

endmodule

### sv/spsc_queue.sv
// ----------------------------------------------------------------------------
// spsc_queue
// Short first-in first-out queue of classified bytes between the front
// and the pattern back end.
// ----------------------------------------------------------------------------
module spsc_queue #(
	parameter int unsigned DEPTH = spsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  spsc_pkg::chk_item_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                rvalid,
	output spsc_pkg::chk_item_t rdata
);
	import spsc_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	chk_item_t     slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// fill count stays in range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");

	// nothing is written into a full queue or read from an empty one
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !rvalid))
		else $error("queue overrun or underrun");

endmodule

### sv/spsc_back.sv
// ----------------------------------------------------------------------------
// spsc_back
// Pattern back end: computes the expected byte through a pipelined 64-bit
// hash, compares it and resolves mismatch failures in stream order.
// ----------------------------------------------------------------------------
module spsc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [spsc_pkg::SEED_W-1:0]  seed,
	input  logic                         q_valid,
	input  spsc_pkg::chk_item_t          q_data,
	output logic                         q_pop,
	input  logic                         out_stall,
	output logic                         out_valid,
	output spsc_pkg::out_beat_t          out_data
);
	import spsc_pkg::*;

	localparam logic [31:0] GOLD_LO = GOLDEN[31:0];
	localparam logic [31:0] GOLD_HI = GOLDEN[63:32];

	logic adv;

	logic        valid_s1;
	chk_item_t   item_s1;
	logic [63:0] x_s1;

	logic        valid_s2;
	chk_item_t   item_s2;
	logic [63:0] plo_s2;
	logic [31:0] cr1_s2;
	logic [31:0] cr2_s2;

	logic               fail_q;
	logic [COUNT_W-1:0] fail_count_q;
	logic               out_valid_q;
	out_beat_t          out_q;

	logic [63:0]       x_in;
	logic [63:0]       y;
	logic [63:0]       z;
	logic [BYTE_W-1:0] exp_byte;
	logic              miss;

	// the whole pipeline moves unless a result is held
	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;

	// hash input: word index mixed with the shifted seed
	assign x_in = (64'(q_data.byte_offset) >> OFF_SHIFT) ^ (64'(seed) << SEED_SHIFT);

	// stage 1: hash input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_data;
			x_s1    <= x_in;
		end
	end

	// stage 2: partial products of the golden-ratio multiply, mod 2^64
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			item_s2 <= item_s1;
			plo_s2  <= 64'(x_s1[31:0]) * 64'(GOLD_LO);
			cr1_s2  <= x_s1[31:0] * GOLD_HI;
			cr2_s2  <= x_s1[63:32] * GOLD_LO;
		end
	end

	// stage 3: sum, xor-shift, byte select and compare
	always_comb begin
		y        = plo_s2 + {cr1_s2 + cr2_s2, 32'd0};
		z        = y ^ (y >> MIX_SHIFT);
		exp_byte = z[{item_s2.byte_offset[2:0], 3'b000} +: BYTE_W];
		miss     = item_s2.check && (item_s2.rx_byte != exp_byte);
	end

	// mismatch failure, kept in stream order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q       <= 1'b0;
			fail_count_q <= '0;
		end else if (adv && valid_s2 && !fail_q && miss) begin
			fail_q       <= 1'b1;
			fail_count_q <= item_s2.count_before;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			if (fail_q) begin
				out_q.status         <= ST_IGNORED;
				out_q.byte_offset    <= fail_count_q;
				out_q.excess_bytes   <= '0;
				out_q.verified_bytes <= fail_count_q;
				out_q.stream_passed  <= 1'b0;
			end else if (miss) begin
				out_q.status         <= ST_MISMATCH;
				out_q.byte_offset    <= item_s2.byte_offset;
				out_q.excess_bytes   <= '0;
				out_q.verified_bytes <= item_s2.count_before;
				out_q.stream_passed  <= 1'b0;
			end else begin
				out_q.status         <= item_s2.status;
				out_q.byte_offset    <= item_s2.byte_offset;
				out_q.excess_bytes   <= item_s2.excess_bytes;
				out_q.verified_bytes <= item_s2.verified_bytes;
				out_q.stream_passed  <= item_s2.stream_passed;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a mismatch failure is never cleared except by reset
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q |=> fail_q && $stable(fail_count_q))
		else $error("mismatch failure state changed");

	// every byte behind a mismatch comes out ignored
	a_ignore_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2 && fail_q) |=>
			(out_q.status == ST_IGNORED) && !out_q.stream_passed)
		else $error("byte after mismatch not ignored");

endmodule

### test/spsc_stream_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spsc_stream_monitor
// Watches the config port and both beat channels of the seeded pattern stream
// checker, predicts every result beat from its own model of the chunk
// bookkeeping and the pattern hash, and compares results in order. Also holds
// the small helper package shared with the stimulus side.
// ----------------------------------------------------------------------------

package spsc_tb_pkg;

	import spsc_pkg::*;

	// expected pattern byte at a stream offset for a given seed
	function automatic logic [BYTE_W-1:0] pattern_byte(logic [SEED_W-1:0] seed,
			logic [COUNT_W-1:0] off);
		logic [63:0] mix;
		mix = (64'(off) >> OFF_SHIFT) ^ (64'(seed) << SEED_SHIFT);
		mix = mix * GOLDEN;
		mix = mix ^ (mix >> MIX_SHIFT);
		mix = mix >> {off[2:0], 3'b000};
		return mix[BYTE_W-1:0];
	endfunction

	// bytes a chunk really spans: zero counts as one, large sizes clamp
	function automatic int unsigned chunk_span(logic [SIZE_W-1:0] size_field);
		if (size_field == '0)
			return 1;
		if (size_field > CHUNK_MAX_DEF)
			return CHUNK_MAX_DEF;
		return int'(size_field);
	endfunction

endpackage

module spsc_stream_monitor
	import spsc_pkg::*;
	import spsc_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_beat_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_beat_t             out_data,
	output int                    fail_count,
	output int                    pending,
	output int                    results_seen,
	output int                    chunks_seen,
	output int                    completes_seen
);

	localparam int MAX_REPORTS = 10;

	// shadow of the block's registers and stream state
	logic [SEED_W-1:0]  cur_seed;
	logic [COUNT_W-1:0] cur_total;
	logic [COUNT_W-1:0] verified;
	logic [SIZE_W-1:0]  chunk_pos;
	logic [SIZE_W-1:0]  chunk_len;
	logic               stream_dead;

	out_beat_t expected_results[$];
	out_beat_t want;
	int        n_fail;
	int        n_res;
	int        n_chunk;
	int        n_done;

	// advance the shadow state by one input beat, return the result it causes
	function automatic out_beat_t predict_result(in_beat_t b);
		out_beat_t        r;
		logic [COUNT_W:0] reach;
		logic [COUNT_W:0] over;
		logic             go_on;
		r.status       = ST_IGNORED;
		r.byte_offset  = verified;
		r.excess_bytes = '0;
		go_on          = 1'b1;
		if (!stream_dead && (b.chunk_first || chunk_len != '0)) begin
			// chunk start: size check against the total
			if (b.chunk_first) begin
				chunk_pos = '0;
				chunk_len = SIZE_W'(chunk_span(b.chunk_size));
				reach = {1'b0, verified} + chunk_len;
				if (reach > {1'b0, cur_total}) begin
					over = reach - {1'b0, cur_total};
					r.excess_bytes = (over > EXCESS_MAX) ? EXCESS_MAX : over[SIZE_W-1:0];
					r.status = ST_EXTRA;
					stream_dead = 1'b1;
					chunk_len = '0;
					go_on = 1'b0;
				end
			end
			// byte compare against the pattern
			if (go_on) begin
				r.byte_offset = verified + COUNT_W'(chunk_pos);
				if (b.rx_byte != pattern_byte(cur_seed, r.byte_offset)) begin
					r.status = ST_MISMATCH;
					stream_dead = 1'b1;
					chunk_pos = '0;
					chunk_len = '0;
				end else begin
					chunk_pos = chunk_pos + 1'b1;
					if (chunk_pos >= chunk_len) begin
						verified = verified + COUNT_W'(chunk_len);
						chunk_pos = '0;
						chunk_len = '0;
						r.status = (verified == cur_total) ? ST_COMPLETE : ST_CHUNK;
					end else begin
						r.status = ST_MATCH;
					end
				end
			end
		end
		r.verified_bytes = verified;
		r.stream_passed  = (verified == cur_total) && !stream_dead;
		return r;
	endfunction

	// sample config, result and input beats at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_seed    = SEED_RST;
			cur_total   = TOTAL_RST;
			verified    = '0;
			chunk_pos   = '0;
			chunk_len   = '0;
			stream_dead = 1'b0;
			expected_results.delete();
			n_fail  = 0;
			n_res   = 0;
			n_chunk = 0;
			n_done  = 0;
			fail_count     <= 0;
			pending        <= 0;
			results_seen   <= 0;
			chunks_seen    <= 0;
			completes_seen <= 0;
		end else begin
			// register writes
			if (cfg_wen) begin
				case (cfg_index)
					REG_SEED:  cur_seed = cfg_data[SEED_W-1:0];
					REG_TOTAL: cur_total = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end

			// result beat against the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected: status %0d offset %0d",
							$realtime, out_data.status, out_data.byte_offset);
				end else begin
					want = expected_results.pop_front();
					n_res++;
					if (want.status == ST_CHUNK || want.status == ST_COMPLETE)
						n_chunk++;
					if (want.status == ST_COMPLETE)
						n_done++;
					if (out_data.status !== want.status ||
							out_data.byte_offset !== want.byte_offset ||
							out_data.excess_bytes !== want.excess_bytes ||
							out_data.verified_bytes !== want.verified_bytes ||
							out_data.stream_passed !== want.stream_passed) begin
						n_fail++;
						if (n_fail <= MAX_REPORTS) begin
							$display("%0t: result %0d differs", $realtime, n_res);
							$display("  exp status %0d offset %0d excess %0d verified %0d passed %0b",
								want.status, want.byte_offset, want.excess_bytes,
								want.verified_bytes, want.stream_passed);
							$display("  got status %0d offset %0d excess %0d verified %0d passed %0b",
								out_data.status, out_data.byte_offset, out_data.excess_bytes,
								out_data.verified_bytes, out_data.stream_passed);
						end
					end
				end
			end

			// input beat
			if (in_valid && !in_stall)
				expected_results.push_back(predict_result(in_data));

			fail_count     <= n_fail;
			pending        <= expected_results.size();
			results_seen   <= n_res;
			chunks_seen    <= n_chunk;
			completes_seen <= n_done;
		end
	end

endmodule

### test/tb_seeded_pattern_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seeded_pattern_stream_checker
// Drives chunked byte streams into the seeded pattern stream checker: a short
// directed opening, then random phases of mostly correct chunks mixed with
// stray bytes and dropped chunks under changing seeds and totals, a run of
// bytes inside a largest-size chunk, and a closing failure. Both channels idle
// at random; the monitor beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_seeded_pattern_stream_checker;

	import spsc_pkg::*;
	import spsc_tb_pkg::*;

	localparam int     HOLD_CYCLES = 200;
	localparam int     TAIL_CYCLES = 10;
	localparam longint TIMEOUT_NS  = 5_000_000;

	typedef enum int {
		END_MISMATCH,
		END_LOWERED,
		END_OVERRUN
	} finale_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_beat_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_beat_t             out_data;

	int fail_count;
	int pending;
	int results_seen;
	int chunks_seen;
	int completes_seen;

	// stimulus-side view of the stream
	logic [COUNT_W-1:0] stream_pos;
	logic [SEED_W-1:0]  seed_now;
	logic [COUNT_W-1:0] total_now;
	bit                 chunk_open;
	int                 beats_sent;
	int                 strays_sent;
	int                 cfg_writes;
	int                 idle_pct;
	int                 stall_pct;
	int                 hold_reqs;
	finale_e            finale;

	seeded_pattern_stream_checker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	spsc_stream_monitor u_mon (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.chunks_seen    (chunks_seen),
		.completes_seen (completes_seen)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one input beat, with a random gap ahead of it
	task automatic send_beat(input logic [BYTE_W-1:0] rx, input logic first,
			input logic [SIZE_W-1:0] size_field);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= '{rx_byte: rx, chunk_first: first, chunk_size: size_field};
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// byte with no chunk open: ignored, stream stays healthy
	task automatic send_stray(input logic [BYTE_W-1:0] rx);
		send_beat(rx, 1'b0, SIZE_W'($urandom));
		strays_sent++;
	endtask

	// first nbytes of a correct chunk; the chunk closes when nbytes covers it
	task automatic send_chunk(input logic [SIZE_W-1:0] size_field, input int nbytes);
		int span;
		int i;
		span = chunk_span(size_field);
		for (i = 0; i < nbytes; i++)
			send_beat(pattern_byte(seed_now, stream_pos + COUNT_W'(i)), i == 0,
				(i == 0) ? size_field : SIZE_W'($urandom));
		beats_sent += nbytes;
		if (nbytes == span) begin
			stream_pos += COUNT_W'(span);
			chunk_open = 1'b0;
		end else begin
			chunk_open = 1'b1;
		end
	endtask

	// stop sending until every expected result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// seed then total, on back-to-back edges
	task automatic write_cfg(input logic [SEED_W-1:0] seed, input logic [COUNT_W-1:0] total);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_SEED;
		cfg_data  <= CFG_DATA_W'(seed);
		@(posedge clk);
		cfg_index <= REG_TOTAL;
		cfg_data  <= CFG_DATA_W'(total);
		@(posedge clk);
		cfg_wen   <= 1'b0;
		seed_now   = seed;
		total_now  = total;
		cfg_writes += 2;
	endtask

	// random mix of chunks; when landing, stop exactly on the total
	task automatic random_phase(input int n_beats, input bit land);
		int                goal;
		int                left;
		int                len;
		int                pick;
		int                top;
		logic [SIZE_W-1:0] sf;
		goal = beats_sent + n_beats;
		left = land ? int'(total_now - stream_pos) : 0;
		while (land ? (left > 0) : (beats_sent < goal)) begin
			pick = $urandom_range(99);
			if (pick < 8 && !chunk_open) begin
				send_stray(BYTE_W'($urandom));
			end else if (pick < 18 && (!land || left >= 2)) begin
				// dropped chunk: a few bytes, then the next chunk replaces it
				top = land ? ((left > 32767) ? 32767 : left) : 32767;
				sf = SIZE_W'($urandom_range(2, top));
				len = chunk_span(sf) - 1;
				send_chunk(sf, $urandom_range(1, (len > 6) ? 6 : len));
			end else begin
				len = $urandom_range(1, 24);
				if (land && len > left)
					len = left;
				sf = SIZE_W'(len);
				if (len == 1 && $urandom_range(1) == 1)
					sf = '0;
				send_chunk(sf, len);
				left -= len;
			end
		end
	endtask

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		int holds_served;
		hold_left    = 0;
		holds_served = 0;
		out_stall    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != hold_reqs) begin
				hold_left = HOLD_CYCLES;
				holds_served++;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [SEED_W-1:0]  s;
		logic [COUNT_W-1:0] t;
		int                 p;
		bit                 land;
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_index   = REG_SEED;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		stream_pos  = '0;
		seed_now    = SEED_RST;
		total_now   = TOTAL_RST;
		chunk_open  = 1'b0;
		beats_sent  = 0;
		strays_sent = 0;
		cfg_writes  = 0;
		idle_pct    = 38;
		stall_pct   = 38;
		hold_reqs   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening under reset settings
		send_stray(8'h00);
		send_chunk(15'd0, 1);          // zero size counts as one
		send_chunk(15'd1, 1);
		send_chunk(15'h7FFF, 2);       // clamped size, left open
		send_chunk(15'd16385, 1);      // replaces the open chunk, left open
		send_chunk(15'd5, 5);
		send_stray(8'hFF);
		send_chunk(15'd16384, 1);      // largest size, left open
		send_chunk(15'd3, 3);
		drain_results();
		write_cfg(32'h0000_0000, stream_pos + 4);
		send_chunk(15'd4, 4);          // lands on the total
		send_stray(8'h5A);             // after completion, pass flag holds
		drain_results();
		write_cfg(32'hFFFF_FFFF, '1);

		// random phases with changing seed and total
		for (p = 0; p < 10; p++) begin
			land = (p % 3 == 1);
			if (p == 3)
				s = '0;
			else if (p == 4)
				s = '1;
			else
				s = SEED_W'($urandom);
			if (land)
				t = stream_pos + COUNT_W'($urandom_range(60, 300));
			else if (p % 2 == 0)
				t = '1;
			else
				t = stream_pos + COUNT_W'($urandom_range(40000, 1 << 30));
			drain_results();
			write_cfg(s, t);
			idle_pct  = (p == 5) ? 0 : 38;
			stall_pct = (p == 5) ? 0 : 38;
			if (p == 2 || p == 7)
				hold_reqs <= hold_reqs + 1;
			random_phase(180, land);
		end

		// a run of bytes inside a chunk of the largest size, left open
		drain_results();
		idle_pct  = 38;
		stall_pct = 38;
		write_cfg(SEED_W'($urandom), '1);
		send_chunk(15'd16384, 48);

		// close the stream with a failure, then bytes that get ignored
		finale = finale_e'($urandom_range(2));
		case (finale)
			END_MISMATCH: begin
				send_chunk(15'd8, 3);
				send_beat(pattern_byte(seed_now, stream_pos + 3) ^ (8'h01 << $urandom_range(7)),
					1'b0, SIZE_W'($urandom));
			end
			END_LOWERED: begin
				// total below the count, oversized chunk clamped
				drain_results();
				write_cfg(seed_now, ($urandom_range(1) == 1) ? '0 :
					COUNT_W'($urandom_range(1, 100)));
				send_beat(pattern_byte(seed_now, stream_pos), 1'b1,
					SIZE_W'(16384 + $urandom_range(0, 16383)));
			end
			default: begin
				drain_results();
				write_cfg(seed_now, stream_pos + 5);
				send_beat(pattern_byte(seed_now, stream_pos), 1'b1, 15'd9);
			end
		endcase
		repeat (12)
			send_beat(BYTE_W'($urandom), 1'($urandom), SIZE_W'($urandom));

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d chunk bytes, %0d stray bytes, %0d register writes, %0d results",
			beats_sent, strays_sent, cfg_writes, results_seen);
		$display("%0d chunks verified, %0d stream completions, closed by %s",
			chunks_seen, completes_seen, finale.name());
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
